@@ hdl/pfd_pkg.sv @@
// Shared types, constants and helper functions of the Playfair digraph encryptor.
// Used by pfd_cell, pfd_chain and playfair_digraph_encrypt; depends on nothing.
package pfd_pkg;

  localparam int SIDE      = 5;
  localparam int CELLS     = SIDE * SIDE;
  localparam int NUM_QUERY = 3;
  localparam int LW        = 5;
  localparam int REG_W     = 2 * SIDE * LW;

  typedef logic [LW-1:0] letter_t;
  typedef logic [2:0]    idx_t;
  typedef logic [4:0]    cell_idx_t;
  typedef logic [1:0]    q_idx_t;
  typedef logic [CELLS-1:0][LW-1:0] square_t;

  localparam letter_t LETTER_I = letter_t'(8);
  localparam letter_t LETTER_J = letter_t'(9);
  localparam letter_t LETTER_X = letter_t'(23);

  // Query slots carried by every search token.
  localparam q_idx_t Q_HELD  = 2'd0;
  localparam q_idx_t Q_PLAIN = 2'd1;
  localparam q_idx_t Q_FILL  = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] REG_ROWS_01 = 2'd0;
  localparam logic [1:0] REG_ROWS_23 = 2'd1;
  localparam logic [1:0] REG_ROW_4   = 2'd2;

  typedef struct packed {
    logic                          valid;
    logic                          msg_end;
    letter_t [NUM_QUERY-1:0]       letter;
    logic    [NUM_QUERY-1:0]       found;
    idx_t    [NUM_QUERY-1:0]       row;
    idx_t    [NUM_QUERY-1:0]       col;
  } token_t;

  function automatic idx_t wrap_inc(input idx_t v);
    return (v == idx_t'(SIDE - 1)) ? idx_t'(0) : idx_t'(v + idx_t'(1));
  endfunction

  function automatic letter_t cell_lookup(input square_t sq, input idx_t row, input idx_t col);
    cell_idx_t idx;
    idx = cell_idx_t'(row) * cell_idx_t'(SIDE) + cell_idx_t'(col);
    return sq[idx];
  endfunction

endpackage

@@ hdl/pfd_cell.sv @@
// One cell of the key-square search chain: holds a square position and checks
// every query letter of the passing token against it. Depends on pfd_pkg.
module pfd_cell (
  input  logic             clk,
  input  logic             rst,
  input  pfd_pkg::letter_t cell_letter,
  input  pfd_pkg::idx_t    cell_row,
  input  pfd_pkg::idx_t    cell_col,
  input  pfd_pkg::token_t  tok_in,
  output pfd_pkg::token_t  tok_out
);

  pfd_pkg::token_t tok_next;

  // The first matching cell in row-major order wins, so a found query is left alone.
  always_comb begin
    tok_next = tok_in;
    for (int k = 0; k < pfd_pkg::NUM_QUERY; k++) begin
      if (!tok_in.found[k] && (tok_in.letter[k] == cell_letter)) begin
        tok_next.found[k] = 1'b1;
        tok_next.row[k]   = cell_row;
        tok_next.col[k]   = cell_col;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else begin
      tok_out.valid <= tok_next.valid;
    end
    tok_out.msg_end <= tok_next.msg_end;
    tok_out.letter  <= tok_next.letter;
    tok_out.found   <= tok_next.found;
    tok_out.row     <= tok_next.row;
    tok_out.col     <= tok_next.col;
  end

endmodule

@@ hdl/pfd_chain.sv @@
// Row of 25 search cells, one per key-square position, passing a token along.
// Depends on pfd_pkg and pfd_cell.
module pfd_chain (
  input  logic              clk,
  input  logic              rst,
  input  pfd_pkg::square_t  square,
  input  pfd_pkg::token_t   tok_in,
  output pfd_pkg::token_t   tok_out
);

  pfd_pkg::token_t link [pfd_pkg::CELLS+1];

  assign link[0] = tok_in;

  for (genvar k = 0; k < pfd_pkg::CELLS; k++) begin : g_cell
    pfd_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .cell_letter (square[k]),
      .cell_row    (pfd_pkg::idx_t'(k / pfd_pkg::SIDE)),
      .cell_col    (pfd_pkg::idx_t'(k % pfd_pkg::SIDE)),
      .tok_in      (link[k]),
      .tok_out     (link[k+1])
    );
  end

  assign tok_out = link[pfd_pkg::CELLS];

endmodule

@@ hdl/playfair_digraph_encrypt.sv @@
// Playfair digraph encryptor over a key square loaded through the write port.
// Depends on pfd_pkg and pfd_chain (which instantiates pfd_cell).
//
// Each accepted letter is done before the next one is accepted: the accepting
// edge puts its search token into the first of 25 square cells, the rest of the
// chain walks it on (locating the held letter, the new letter and the filler X
// in one pass), the search state encrypts the pair and the load state loads the
// results. Results (0, 2 or 4 per letter) leave one per cycle while m_tready is
// high, from a four-entry output buffer, and the next letter is accepted and
// searched while earlier results still drain. A letter with results waits in its
// load state, holding off the next accept, until the buffer has emptied.
module playfair_digraph_encrypt (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [1:0]                cfg_index,
  input  logic [pfd_pkg::REG_W-1:0] cfg_data,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [7:0]                s_tdata,   // [4:0] plain_letter
  input  logic                      s_tlast,   // message_end
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [7:0]                m_tdata,   // [4:0] cipher_letter
  output logic                      m_tlast    // run_last
);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SEARCH = 3'b010,
    ST_LOAD   = 3'b100
  } state_t;

  state_t state;

  logic [pfd_pkg::REG_W-1:0]   sq01, sq23;
  logic [pfd_pkg::REG_W/2-1:0] sq4;
  pfd_pkg::square_t square;

  pfd_pkg::letter_t held_letter;
  logic             held_valid;

  pfd_pkg::token_t tok_in, tok_out;

  pfd_pkg::letter_t pend0, pend1;
  logic [2:0]       pend_n;

  pfd_pkg::letter_t buf_letter [4];
  logic [3:0]       buf_last;
  logic [2:0]       count;

  logic             in_acc, out_acc;
  pfd_pkg::letter_t plain_mapped;

  // Decision and pair encryption signals.
  logic             keep_new, clear_held;
  logic [2:0]       n_res;
  pfd_pkg::q_idx_t  qa, qb;
  pfd_pkg::letter_t a, b, enc0, enc1;
  logic             fa, fb;
  pfd_pkg::idx_t    ra, ca, rb, cb;

  assign square = {sq4, sq23, sq01};

  always_ff @(posedge clk) begin
    if (rst) begin
      sq01 <= '0;
      sq23 <= '0;
      sq4  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pfd_pkg::REG_ROWS_01: sq01 <= cfg_data;
        pfd_pkg::REG_ROWS_23: sq23 <= cfg_data;
        pfd_pkg::REG_ROW_4:   sq4  <= cfg_data[pfd_pkg::REG_W/2-1:0];
        default: ;
      endcase
    end
  end

  assign s_tready = (state == ST_IDLE);
  assign in_acc   = s_tvalid && s_tready;
  assign out_acc  = m_tvalid && m_tready;

  assign plain_mapped = (s_tdata[4:0] == pfd_pkg::LETTER_I) ? pfd_pkg::LETTER_J : s_tdata[4:0];

  always_comb begin
    tok_in                        = '0;
    tok_in.valid                  = in_acc;
    tok_in.msg_end                = s_tlast;
    tok_in.letter[pfd_pkg::Q_HELD]  = held_letter;
    tok_in.letter[pfd_pkg::Q_PLAIN] = plain_mapped;
    tok_in.letter[pfd_pkg::Q_FILL]  = pfd_pkg::LETTER_X;
  end

  pfd_chain u_chain (
    .clk     (clk),
    .rst     (rst),
    .square  (square),
    .tok_in  (tok_in),
    .tok_out (tok_out)
  );

  // Every emitted pair is (held, X), (new, X) or (held, new); a doubled
  // letter at message end repeats the (held, X) pair.
  always_comb begin
    keep_new   = 1'b0;
    clear_held = 1'b0;
    n_res      = 3'd0;
    qa         = pfd_pkg::Q_HELD;
    qb         = pfd_pkg::Q_FILL;
    priority if (!tok_out.found[pfd_pkg::Q_PLAIN]) begin
      if (tok_out.msg_end && held_valid) begin
        n_res      = 3'd2;
        clear_held = 1'b1;
      end
    end else if (!held_valid) begin
      qa = pfd_pkg::Q_PLAIN;
      if (tok_out.msg_end) begin
        n_res = 3'd2;
      end else begin
        keep_new = 1'b1;
      end
    end else if (held_letter == tok_out.letter[pfd_pkg::Q_PLAIN]) begin
      n_res      = tok_out.msg_end ? 3'd4 : 3'd2;
      clear_held = tok_out.msg_end;
    end else begin
      qb         = pfd_pkg::Q_PLAIN;
      n_res      = 3'd2;
      clear_held = 1'b1;
    end

    a  = tok_out.letter[qa];
    b  = tok_out.letter[qb];
    fa = tok_out.found[qa];
    fb = tok_out.found[qb];
    ra = tok_out.row[qa];
    ca = tok_out.col[qa];
    rb = tok_out.row[qb];
    cb = tok_out.col[qb];

    priority if (!(fa && fb)) begin
      enc0 = a;
      enc1 = b;
    end else if (ra == rb) begin
      enc0 = pfd_pkg::cell_lookup(square, ra, pfd_pkg::wrap_inc(ca));
      enc1 = pfd_pkg::cell_lookup(square, rb, pfd_pkg::wrap_inc(cb));
    end else if (ca == cb) begin
      enc0 = pfd_pkg::cell_lookup(square, pfd_pkg::wrap_inc(ra), ca);
      enc1 = pfd_pkg::cell_lookup(square, pfd_pkg::wrap_inc(rb), cb);
    end else begin
      enc0 = pfd_pkg::cell_lookup(square, ra, cb);
      enc1 = pfd_pkg::cell_lookup(square, rb, ca);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      held_valid <= 1'b0;
      pend_n     <= 3'd0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_acc) begin
            state <= ST_SEARCH;
          end
        end
        ST_SEARCH: begin
          if (tok_out.valid) begin
            pend_n <= n_res;
            state  <= ST_LOAD;
            if (keep_new) begin
              held_valid <= 1'b1;
            end else if (clear_held) begin
              held_valid <= 1'b0;
            end
          end
        end
        ST_LOAD: begin
          if (pend_n == 3'd0 || count == 3'd0) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_letter <= '0;
    end else if (state == ST_SEARCH && tok_out.valid) begin
      pend0 <= enc0;
      pend1 <= enc1;
      if (keep_new) begin
        held_letter <= tok_out.letter[pfd_pkg::Q_PLAIN];
      end
    end
  end

  // Output buffer: entry 0 is the item on offer; a pop shifts the rest down.
  // It is loaded only when empty, so a load and a pop never meet.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 3'd0;
    end else if (state == ST_LOAD && pend_n != 3'd0 && count == 3'd0) begin
      count <= pend_n;
    end else if (out_acc) begin
      count <= count - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_LOAD && pend_n != 3'd0 && count == 3'd0) begin
      buf_letter[0] <= pend0;
      buf_letter[1] <= pend1;
      buf_letter[2] <= pend0;
      buf_letter[3] <= pend1;
      buf_last      <= (pend_n == 3'd4) ? 4'b1000 : 4'b0010;
    end else if (out_acc) begin
      buf_letter[0] <= buf_letter[1];
      buf_letter[1] <= buf_letter[2];
      buf_letter[2] <= buf_letter[3];
      buf_last      <= {1'b0, buf_last[3:1]};
    end
  end

  assign m_tvalid = (count != 3'd0);
  assign m_tdata  = {3'b000, buf_letter[0]};
  assign m_tlast  = buf_last[0];

  a_chain_only_in_search: assert property (@(posedge clk) disable iff (rst)
    tok_out.valid |-> (state == ST_SEARCH))
    else $error("search token left the chain outside the search state");

  a_accept_starts_search: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> (state == ST_SEARCH))
    else $error("accepted item did not start a search");

  a_load_count: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LOAD && pend_n != 3'd0 && count == 3'd0) |=> (count == $past(pend_n)))
    else $error("output buffer count does not match the loaded results");

  a_last_on_final: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && count == 3'd1) |-> m_tlast)
    else $error("final buffered result of an item is not marked last");

endmodule

@@ tb/sv/playfair_cipher_checker.sv @@
// Checker for the Playfair digraph encryptor: tracks the key square and the pending letter,
// predicts the cipher letters of every accepted plain letter and compares them in order.
// Depends on pfd_pkg for the letter type, the square geometry and the register indexes.
module playfair_cipher_checker (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [1:0]                cfg_index,
  input  logic [pfd_pkg::REG_W-1:0] cfg_data,
  input  logic                      s_tvalid,
  input  logic                      s_tready,
  input  logic [7:0]                s_tdata,   // [4:0] plain_letter
  input  logic                      s_tlast,   // message_end
  input  logic                      m_tvalid,
  input  logic                      m_tready,
  input  logic [7:0]                m_tdata,   // [4:0] cipher_letter
  input  logic                      m_tlast,   // run_last
  output int                        mismatches,
  output int                        outstanding
);

  typedef struct packed {
    pfd_pkg::letter_t letter;
    logic             last;
  } cipher_item_t;

  cipher_item_t                         expected_cipher[$];
  logic [pfd_pkg::REG_W-1:0]            rows_01 = '0;
  logic [pfd_pkg::REG_W-1:0]            rows_23 = '0;
  logic [pfd_pkg::SIDE*pfd_pkg::LW-1:0] row_4 = '0;
  pfd_pkg::letter_t                     held = '0;
  logic                                 held_ok = 1'b0;
  int                                   fault_count = 0;
  int                                   waiting_count = 0;

  assign mismatches  = fault_count;
  assign outstanding = waiting_count;

  function automatic pfd_pkg::letter_t square_cell(input int k);
    if (k < 10) return rows_01[pfd_pkg::LW*k +: pfd_pkg::LW];
    if (k < 20) return rows_23[pfd_pkg::LW*(k-10) +: pfd_pkg::LW];
    return row_4[pfd_pkg::LW*(k-20) +: pfd_pkg::LW];
  endfunction

  // Scanning downward leaves the first row-major match, so repeated letters
  // resolve to their earliest cell.
  function automatic logic find_letter(input pfd_pkg::letter_t l, output int r,
                                       output int c);
    int   k;
    logic hit;
    hit = 1'b0;
    r = 0;
    c = 0;
    for (k = pfd_pkg::CELLS - 1; k >= 0; k--) begin
      if (square_cell(k) == l) begin
        r = k / pfd_pkg::SIDE;
        c = k % pfd_pkg::SIDE;
        hit = 1'b1;
      end
    end
    return hit;
  endfunction

  task automatic add_pair(input pfd_pkg::letter_t a, input pfd_pkg::letter_t b);
    int               ra, ca, rb, cb;
    pfd_pkg::letter_t ea, eb;
    cipher_item_t     item;
    if (!find_letter(a, ra, ca) || !find_letter(b, rb, cb)) begin
      // A letter missing from the square passes the pair through untouched.
      ea = a;
      eb = b;
    end else if (ra == rb) begin
      ea = square_cell(ra * pfd_pkg::SIDE + (ca + 1) % pfd_pkg::SIDE);
      eb = square_cell(rb * pfd_pkg::SIDE + (cb + 1) % pfd_pkg::SIDE);
    end else if (ca == cb) begin
      ea = square_cell(((ra + 1) % pfd_pkg::SIDE) * pfd_pkg::SIDE + ca);
      eb = square_cell(((rb + 1) % pfd_pkg::SIDE) * pfd_pkg::SIDE + cb);
    end else begin
      ea = square_cell(ra * pfd_pkg::SIDE + cb);
      eb = square_cell(rb * pfd_pkg::SIDE + ca);
    end
    item.last = 1'b0;
    item.letter = ea;
    expected_cipher.push_back(item);
    item.letter = eb;
    expected_cipher.push_back(item);
  endtask

  task automatic predict_letter(input pfd_pkg::letter_t raw, input logic msg_end);
    pfd_pkg::letter_t l;
    int               r, c, start_n;
    cipher_item_t     tail;
    l = (raw == pfd_pkg::LETTER_I) ? pfd_pkg::LETTER_J : raw;
    start_n = expected_cipher.size();
    if (!find_letter(l, r, c)) begin
      if (msg_end && held_ok) begin
        add_pair(held, pfd_pkg::LETTER_X);
        held_ok = 1'b0;
      end
    end else if (!held_ok) begin
      if (msg_end) begin
        add_pair(l, pfd_pkg::LETTER_X);
      end else begin
        held = l;
        held_ok = 1'b1;
      end
    end else if (held == l) begin
      add_pair(held, pfd_pkg::LETTER_X);
      if (msg_end) begin
        add_pair(l, pfd_pkg::LETTER_X);
        held_ok = 1'b0;
      end
    end else begin
      add_pair(held, l);
      held_ok = 1'b0;
    end
    if (expected_cipher.size() > start_n) begin
      tail = expected_cipher.pop_back();
      tail.last = 1'b1;
      expected_cipher.push_back(tail);
    end
  endtask

  task automatic check_cipher(input pfd_pkg::letter_t got, input logic got_last);
    cipher_item_t want;
    if (expected_cipher.size() == 0) begin
      $display("%0t: cipher letter expected none, got %0d (last %0b)", $time, got, got_last);
      fault_count++;
    end else begin
      want = expected_cipher.pop_front();
      if (got !== want.letter) begin
        $display("%0t: cipher letter expected %0d, got %0d", $time, want.letter, got);
        fault_count++;
      end
      if (got_last !== want.last) begin
        $display("%0t: run end flag expected %0b, got %0b", $time, want.last, got_last);
        fault_count++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      rows_01 = '0;
      rows_23 = '0;
      row_4 = '0;
      held = '0;
      held_ok = 1'b0;
      expected_cipher.delete();
    end else begin
      if (m_tvalid && m_tready) check_cipher(m_tdata[pfd_pkg::LW-1:0], m_tlast);
      if (cfg_we) begin
        case (cfg_index)
          pfd_pkg::REG_ROWS_01: rows_01 = cfg_data;
          pfd_pkg::REG_ROWS_23: rows_23 = cfg_data;
          pfd_pkg::REG_ROW_4:   row_4 = cfg_data[pfd_pkg::SIDE*pfd_pkg::LW-1:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) predict_letter(s_tdata[pfd_pkg::LW-1:0], s_tlast);
    end
    waiting_count <= expected_cipher.size();
  end

endmodule

@@ tb/sv/testbench.sv @@
// Top of the Playfair digraph encryptor bench: clock, reset, key square loads and letter
// stimulus, with a back-pressuring receiver. Depends on pfd_pkg, the block and the checker.
module testbench;

  typedef enum {SQUARE_ORDERED, SQUARE_KEYED, SQUARE_NO_FILLER, SQUARE_JUNK,
                SQUARE_ZERO, SQUARE_ONES} square_kind_t;
  typedef enum {READY_ALWAYS, READY_COIN, READY_EVERY_FOURTH, READY_SPARSE} ready_mode_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      cfg_we = 1'b0;
  logic [1:0]                cfg_index = pfd_pkg::REG_ROWS_01;
  logic [pfd_pkg::REG_W-1:0] cfg_data = '0;
  logic                      s_tvalid = 1'b0;
  logic                      s_tready;
  logic [7:0]                s_tdata = '0;   // [4:0] plain_letter
  logic                      s_tlast = 1'b0; // message_end
  logic                      m_tvalid;
  logic                      m_tready = 1'b0;
  logic [7:0]                m_tdata;        // [4:0] cipher_letter
  logic                      m_tlast;        // run_last
  int                        mismatches;
  int                        outstanding;

  pfd_pkg::letter_t key_cells[pfd_pkg::CELLS];
  int               burst_left = 0;
  ready_mode_t      ready_mode = READY_ALWAYS;
  int               ready_span = 0;
  square_kind_t     plan[10] = '{SQUARE_ZERO, SQUARE_KEYED, SQUARE_ONES, SQUARE_KEYED,
                                 SQUARE_JUNK, SQUARE_KEYED, SQUARE_NO_FILLER, SQUARE_KEYED,
                                 SQUARE_JUNK, SQUARE_KEYED};

  playfair_digraph_encrypt dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
  );

  playfair_cipher_checker u_checker (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .mismatches(mismatches), .outstanding(outstanding)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // The receiver switches between randomly chosen stall patterns.
  always @(posedge clk) begin
    if (ready_span == 0) begin
      ready_mode <= ready_mode_t'($urandom_range(0, 3));
      ready_span <= $urandom_range(20, 120);
    end else begin
      ready_span <= ready_span - 1;
    end
    case (ready_mode)
      READY_ALWAYS:       m_tready <= 1'b1;
      READY_COIN:         m_tready <= 1'($urandom_range(0, 1));
      READY_EVERY_FOURTH: m_tready <= (ready_span % 4 == 0);
      default:            m_tready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  function automatic pfd_pkg::letter_t ch(input byte c);
    return pfd_pkg::letter_t'(c - 8'd65);
  endfunction

  task automatic send_letter(input pfd_pkg::letter_t letter, input logic msg_end);
    s_tvalid <= 1'b1;
    s_tdata <= {3'b000, letter};
    s_tlast <= msg_end;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 40)) @(posedge clk);
      burst_left = ($urandom_range(0, 9) == 0) ? 60 : $urandom_range(0, 12);
    end
  endtask

  // Holds the sender off until every predicted letter is out and the
  // search of a letter that yields nothing has had time to finish.
  task automatic drain_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic build_square(input square_kind_t kind);
    int               k, j, n;
    pfd_pkg::letter_t swap;
    n = 0;
    for (k = 0; k < 26; k++) begin
      if (pfd_pkg::letter_t'(k) != pfd_pkg::LETTER_I) begin
        key_cells[n] = pfd_pkg::letter_t'(k);
        n++;
      end
    end
    if (kind == SQUARE_KEYED || kind == SQUARE_NO_FILLER) begin
      for (k = pfd_pkg::CELLS - 1; k > 0; k--) begin
        j = $urandom_range(0, k);
        swap = key_cells[k];
        key_cells[k] = key_cells[j];
        key_cells[j] = swap;
      end
    end
    for (k = 0; k < pfd_pkg::CELLS; k++) begin
      case (kind)
        SQUARE_NO_FILLER: begin
          if (key_cells[k] == pfd_pkg::LETTER_X)
            key_cells[k] =
              key_cells[(k + $urandom_range(1, pfd_pkg::CELLS - 1)) % pfd_pkg::CELLS];
        end
        SQUARE_JUNK: key_cells[k] = pfd_pkg::letter_t'($urandom_range(0, 31));
        SQUARE_ZERO: key_cells[k] = '0;
        SQUARE_ONES: key_cells[k] = '1;
        default: ;
      endcase
    end
  endtask

  task automatic load_square();
    logic [pfd_pkg::REG_W-1:0] r01, r23, r4;
    int                        k;
    r01 = '0;
    r23 = '0;
    r4 = '0;
    for (k = 0; k < pfd_pkg::CELLS; k++) begin
      if (k < 10) r01[pfd_pkg::LW*k +: pfd_pkg::LW] = key_cells[k];
      else if (k < 20) r23[pfd_pkg::LW*(k-10) +: pfd_pkg::LW] = key_cells[k];
      else r4[pfd_pkg::LW*(k-20) +: pfd_pkg::LW] = key_cells[k];
    end
    cfg_we <= 1'b1;
    cfg_index <= pfd_pkg::REG_ROWS_01;
    cfg_data <= r01;
    @(posedge clk);
    cfg_index <= pfd_pkg::REG_ROWS_23;
    cfg_data <= r23;
    @(posedge clk);
    cfg_index <= pfd_pkg::REG_ROW_4;
    cfg_data <= r4;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Mostly letters of the square, with doubled letters, fillers, I, and
  // codes outside the alphabet mixed in.
  task automatic send_messages(input int count);
    pfd_pkg::letter_t pick, prev;
    int               roll;
    prev = key_cells[0];
    for (int n = 0; n < count; n++) begin
      roll = $urandom_range(0, 99);
      if (roll < 8) pick = pfd_pkg::letter_t'($urandom_range(26, 31));
      else if (roll < 20) pick = prev;
      else if (roll < 26) pick = pfd_pkg::LETTER_X;
      else if (roll < 31) pick = pfd_pkg::LETTER_I;
      else if (roll < 36) pick = pfd_pkg::letter_t'($urandom_range(0, 25));
      else pick = key_cells[$urandom_range(0, pfd_pkg::CELLS - 1)];
      send_letter(pick, $urandom_range(0, 6) == 0);
      prev = pick;
      if ($urandom_range(0, 49) == 0) drain_results();
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Square still at reset: only A is present, so pairs with X pass through.
    send_letter(ch("A"), 1'b0);
    send_letter(ch("A"), 1'b0);
    send_letter(ch("A"), 1'b1);
    send_letter(ch("A"), 1'b0);
    send_letter(pfd_pkg::letter_t'(31), 1'b1);
    drain_results();

    build_square(SQUARE_ORDERED);
    load_square();
    send_letter(ch("A"), 1'b0);
    send_letter(ch("C"), 1'b0);
    send_letter(ch("A"), 1'b0);
    send_letter(ch("Z"), 1'b0);
    send_letter(ch("E"), 1'b0);
    send_letter(ch("A"), 1'b0);
    send_letter(ch("V"), 1'b0);
    send_letter(ch("A"), 1'b0);
    send_letter(pfd_pkg::LETTER_I, 1'b0);
    send_letter(ch("K"), 1'b0);
    send_letter(ch("L"), 1'b0);
    send_letter(ch("L"), 1'b0);
    send_letter(ch("M"), 1'b0);
    send_letter(pfd_pkg::LETTER_X, 1'b0);
    send_letter(pfd_pkg::LETTER_X, 1'b0);
    send_letter(pfd_pkg::LETTER_X, 1'b1);
    send_letter(ch("N"), 1'b1);
    send_letter(ch("P"), 1'b0);
    send_letter(pfd_pkg::letter_t'(27), 1'b1);
    // R stays held across the next square load.
    send_letter(ch("R"), 1'b0);
    drain_results();

    for (int p = 0; p < 10; p++) begin
      build_square(plan[p]);
      load_square();
      send_messages((plan[p] == SQUARE_KEYED) ? 65 : 35);
      drain_results();
    end

    if (mismatches == 0 && outstanding == 0) begin
      $display("playfair_digraph_encrypt verification clean");
    end else begin
      $display("playfair_digraph_encrypt verification failed");
    end
    $finish;
  end

  initial begin
    #12000000;
    $display("playfair_digraph_encrypt verification failed");
    $finish;
  end

endmodule
